[sv/rotation_matrix_to_quaternion_core_assert.svh]
// Assertion macros for the rotation matrix to quaternion core.
// Included by the top-level module, which checks its own pipeline; no other dependencies.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rmq_pkg.sv]
// Shared types for the rotation matrix to quaternion core.
// No dependencies; imported by every module of the core.
package rmq_pkg;

  localparam int FLD_W = 18;

  // Which formula the item uses: trace, or the largest diagonal element.
  typedef enum logic [1:0] {
    SEL_TRACE = 2'd0,
    SEL_X     = 2'd1,
    SEL_Y     = 2'd2,
    SEL_Z     = 2'd3
  } sel_t;

  typedef struct packed {
    logic valid;
    sel_t sel;
  } ctrl_t;

endpackage

[sv/rmq_sqrt_step.sv]
// One registered digit step of the pipelined integer square root.
// Depends on rmq_pkg for the control struct.
module rmq_sqrt_step
  import rmq_pkg::*;
#(
  parameter int VWE = 36,
  parameter int RB  = 18,
  parameter int SW  = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ctrl_t           ctrl_in,
  input  logic [VWE-1:0]  v_in,
  input  logic [RB+1:0]   rem_in,
  input  logic [RB-1:0]   root_in,
  input  logic [SW-1:0]   side_in,
  output ctrl_t           ctrl_out,
  output logic [VWE-1:0]  v_out,
  output logic [RB+1:0]   rem_out,
  output logic [RB-1:0]   root_out,
  output logic [SW-1:0]   side_out
);

  logic [RB+1:0] rem_sh;
  logic [RB+1:0] trial;
  logic          take;

  // Bring in the next two radicand bits and try the next root bit.
  assign rem_sh = {rem_in[RB-1:0], v_in[VWE-1:VWE-2]};
  assign trial  = {root_in, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out    <= {v_in[VWE-3:0], 2'b00};
      rem_out  <= take ? (rem_sh - trial) : rem_sh;
      root_out <= {root_in[RB-2:0], take};
      side_out <= side_in;
    end
  end

endmodule

[sv/rmq_div_step.sv]
// One registered quotient-bit step for three parallel restoring dividers.
// Depends on rmq_pkg for the control struct.
module rmq_div_step
  import rmq_pkg::*;
#(
  parameter int REMW = 20,
  parameter int LW   = 18,
  parameter int QB   = 18,
  parameter int SW   = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  ctrl_t                 ctrl_in,
  input  logic [REMW-2:0]       d_in,
  input  logic [2:0][REMW-1:0]  rem_in,
  input  logic [2:0][LW-1:0]    low_in,
  input  logic [2:0][QB-1:0]    q_in,
  input  logic [SW-1:0]         side_in,
  output ctrl_t                 ctrl_out,
  output logic [REMW-2:0]       d_out,
  output logic [2:0][REMW-1:0]  rem_out,
  output logic [2:0][LW-1:0]    low_out,
  output logic [2:0][QB-1:0]    q_out,
  output logic [SW-1:0]         side_out
);

  logic [2:0][REMW-1:0] rem_sh;
  logic [2:0]           take;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_sh[k] = {rem_in[k][REMW-2:0], low_in[k][LW-1]};
      take[k]   = (rem_sh[k] >= {1'b0, d_in});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out    <= d_in;
      side_out <= side_in;
      for (int k = 0; k < 3; k++) begin
        rem_out[k] <= take[k] ? (rem_sh[k] - {1'b0, d_in}) : rem_sh[k];
        low_out[k] <= {low_in[k][LW-2:0], 1'b0};
        q_out[k]   <= {q_in[k][QB-2:0], take[k]};
      end
    end
  end

endmodule

[sv/rotation_matrix_to_quaternion_core.sv]
// Top level of the rotation matrix to quaternion core (Shepperd's method).
// Depends on rmq_pkg, rmq_sqrt_step, rmq_div_step and the assertion macro header.
//
// Channel  | Dir | tdata fields (low bit up)              | tuser
// ---------+-----+----------------------------------------+-----------
// s        | in  | m00 m01 m02 m10 m11 m12 m20 m21 m22    | -
// m        | out | quat_x quat_y quat_z quat_w            | degenerate
//
// One matrix is accepted every cycle while the output is not stalled, with
// RB = (RADW + FRAC_BITS) / 2 square-root digit stages (RADW = 20 up to
// FRAC_BITS = 17) and QB = FRAC_BITS + 2 quotient-bit stages.
// Synchronous reset clears the valid bits of every stage; data is not reset.
// A stall on the master side freezes the whole pipeline in place; s_tready
// is high whenever the output register is empty or being drained.
module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [167:0] s_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22, 18 b each, 6 b zero
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,   // quat_x quat_y quat_z quat_w, 18 b each
  output logic         m_tuser    // degenerate
);

  `include "rotation_matrix_to_quaternion_core_assert.svh"

  // Signed radicand width; the radicand is at most RADW-1 bits unsigned.
  localparam int RADW  = (FRAC_BITS > 17) ? FRAC_BITS + 3 : 20;
  localparam int VW    = RADW - 1 + FRAC_BITS;
  localparam int RB    = (VW + 1) / 2;
  localparam int VWE   = 2 * RB;
  localparam int QB    = FRAC_BITS + 2;
  localparam int REMW  = RB + 2;
  localparam int MAGW  = 19;
  localparam int NW    = 19;
  localparam int CW    = RB + 3 + MAGW;
  localparam int XW    = FRAC_BITS + 3 + FLD_W;
  localparam int SQ_SW = 3 * NW;
  localparam int DV_SW = RB + 7;
  localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;
  localparam logic signed [RADW-1:0] ONE_R = RADW'(1) << FRAC_BITS;

  logic en;

  // ---------------------------------------------------------------- front
  logic signed [FLD_W-1:0] m [9];
  logic signed [19:0]      trace, e00, e11, e22;
  logic signed [RADW-1:0]  rad;
  logic signed [NW-1:0]    n21m12, n02m20, n10m01, n01p10, n02p20, n12p21;
  sel_t                    sel_c;
  logic [2:0][NW-1:0]      num_c;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m[k] = s_tdata[k*FLD_W +: FLD_W];
    end
    e00    = 20'(m[0]);
    e11    = 20'(m[4]);
    e22    = 20'(m[8]);
    trace  = e00 + e11 + e22;
    n21m12 = NW'(m[7]) - NW'(m[5]);
    n02m20 = NW'(m[2]) - NW'(m[6]);
    n10m01 = NW'(m[3]) - NW'(m[1]);
    n01p10 = NW'(m[1]) + NW'(m[3]);
    n02p20 = NW'(m[2]) + NW'(m[6]);
    n12p21 = NW'(m[5]) + NW'(m[7]);
    if (trace > 0) begin
      sel_c = SEL_TRACE;
      rad   = ONE_R + RADW'(trace);
      num_c = {n10m01, n02m20, n21m12};
    end else if (e00 > e11 && e00 > e22) begin
      sel_c = SEL_X;
      rad   = ONE_R + RADW'(e00) - RADW'(e11) - RADW'(e22);
      num_c = {n21m12, n02p20, n01p10};
    end else if (e11 > e22) begin
      sel_c = SEL_Y;
      rad   = ONE_R + RADW'(e11) - RADW'(e00) - RADW'(e22);
      num_c = {n02m20, n12p21, n01p10};
    end else begin
      sel_c = SEL_Z;
      rad   = ONE_R + RADW'(e22) - RADW'(e00) - RADW'(e11);
      num_c = {n10m01, n12p21, n02p20};
    end
  end

  ctrl_t            f_ctrl;
  logic [VWE-1:0]   f_v;
  logic [SQ_SW-1:0] f_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_ctrl <= '0;
    end else if (en) begin
      f_ctrl.valid <= s_tvalid;
      f_ctrl.sel   <= sel_c;
    end
  end

  // Non-positive radicand feeds zero, so the root comes out zero.
  always_ff @(posedge clk) begin
    if (en) begin
      f_v    <= (rad > 0) ? (VWE'(rad[RADW-2:0]) << FRAC_BITS) : '0;
      f_side <= num_c;
    end
  end

  // ---------------------------------------------------------- square root
  ctrl_t            sq_ctrl [RB+1];
  logic [VWE-1:0]   sq_v    [RB+1];
  logic [RB+1:0]    sq_rem  [RB+1];
  logic [RB-1:0]    sq_root [RB+1];
  logic [SQ_SW-1:0] sq_side [RB+1];

  assign sq_ctrl[0] = f_ctrl;
  assign sq_v[0]    = f_v;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = f_side;

  for (genvar g = 0; g < RB; g++) begin : g_sqrt
    rmq_sqrt_step #(.VWE(VWE), .RB(RB), .SW(SQ_SW)) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (sq_ctrl[g]),
      .v_in     (sq_v[g]),
      .rem_in   (sq_rem[g]),
      .root_in  (sq_root[g]),
      .side_in  (sq_side[g]),
      .ctrl_out (sq_ctrl[g+1]),
      .v_out    (sq_v[g+1]),
      .rem_out  (sq_rem[g+1]),
      .root_out (sq_root[g+1]),
      .side_out (sq_side[g+1])
    );
  end

  // ------------------------------------------------------- divider setup
  logic [RB-1:0]        r_c;
  logic [2:0][NW-1:0]   n_c;
  logic [2:0][MAGW-1:0] mag_c;
  logic [2:0]           neg_c, ovf_c;

  always_comb begin
    r_c = sq_root[RB];
    n_c = sq_side[RB];
    for (int k = 0; k < 3; k++) begin
      neg_c[k] = n_c[k][NW-1];
      mag_c[k] = neg_c[k] ? (MAGW'(0) - n_c[k]) : n_c[k];
      // Quotient of at least four saturates regardless of its low bits.
      ovf_c[k] = (CW'(mag_c[k]) >= (CW'(r_c) << 3));
    end
  end

  ctrl_t                p_ctrl;
  logic [REMW-2:0]      p_d;
  logic [2:0][REMW-1:0] p_rem;
  logic [2:0][QB-1:0]   p_low;
  logic [DV_SW-1:0]     p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctrl <= '0;
    end else if (en) begin
      p_ctrl <= sq_ctrl[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_d    <= {r_c, 1'b0};
      p_side <= {(r_c == '0), neg_c, ovf_c, r_c};
      for (int k = 0; k < 3; k++) begin
        p_rem[k] <= REMW'(mag_c[k] >> 2);
        p_low[k] <= {mag_c[k][1:0], {FRAC_BITS{1'b0}}};
      end
    end
  end

  // ------------------------------------------------------------- divider
  ctrl_t                dv_ctrl [QB+1];
  logic [REMW-2:0]      dv_d    [QB+1];
  logic [2:0][REMW-1:0] dv_rem  [QB+1];
  logic [2:0][QB-1:0]   dv_low  [QB+1];
  logic [2:0][QB-1:0]   dv_q    [QB+1];
  logic [DV_SW-1:0]     dv_side [QB+1];

  assign dv_ctrl[0] = p_ctrl;
  assign dv_d[0]    = p_d;
  assign dv_rem[0]  = p_rem;
  assign dv_low[0]  = p_low;
  assign dv_q[0]    = '0;
  assign dv_side[0] = p_side;

  for (genvar g = 0; g < QB; g++) begin : g_div
    rmq_div_step #(.REMW(REMW), .LW(QB), .QB(QB), .SW(DV_SW)) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (dv_ctrl[g]),
      .d_in     (dv_d[g]),
      .rem_in   (dv_rem[g]),
      .low_in   (dv_low[g]),
      .q_in     (dv_q[g]),
      .side_in  (dv_side[g]),
      .ctrl_out (dv_ctrl[g+1]),
      .d_out    (dv_d[g+1]),
      .rem_out  (dv_rem[g+1]),
      .low_out  (dv_low[g+1]),
      .q_out    (dv_q[g+1]),
      .side_out (dv_side[g+1])
    );
  end

  // -------------------------------------------------------------- finish
  ctrl_t                  e_ctrl;
  logic [RB-1:0]          e_r;
  logic [2:0]             e_ovf, e_neg;
  logic                   e_degen;
  logic [XW-1:0]          quarter, qv;
  logic [2:0][FLD_W-1:0]  lane;
  logic [FLD_W-1:0]       quarter_f;
  logic [3:0][FLD_W-1:0]  quat_c;
  logic [XW-1:0]          sv_x;

  assign e_ctrl                       = dv_ctrl[QB];
  assign {e_degen, e_neg, e_ovf, e_r} = dv_side[QB];

  always_comb begin
    quarter   = XW'(e_r >> 1);
    quarter   = (quarter > ONE_X) ? ONE_X : quarter;
    quarter_f = quarter[FLD_W-1:0];
    for (int k = 0; k < 3; k++) begin
      qv      = XW'(dv_q[QB][k]);
      qv      = (e_ovf[k] || qv > ONE_X) ? ONE_X : qv;
      sv_x    = e_neg[k] ? (XW'(0) - qv) : qv;
      lane[k] = sv_x[FLD_W-1:0];
    end
    // quat_c holds {w, z, y, x}.
    case (e_ctrl.sel)
      SEL_TRACE: quat_c = {quarter_f, lane[2], lane[1], lane[0]};
      SEL_X:     quat_c = {lane[2], lane[1], lane[0], quarter_f};
      SEL_Y:     quat_c = {lane[2], lane[1], quarter_f, lane[0]};
      SEL_Z:     quat_c = {lane[2], quarter_f, lane[1], lane[0]};
      default:   quat_c = '0;
    endcase
    if (e_degen) begin
      quat_c = '0;
    end
  end

  // Advance everything unless a finished result waits on the output.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= e_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= quat_c;
      m_tuser <= e_degen;
    end
  end

  // ----------------------------------------------------------- checks
  `RMQ_ASSERT_NOW(a_degen_zero, m_tvalid && m_tuser, m_tdata == '0, "degenerate result not zero")
  `RMQ_ASSERT_NEXT(a_stall_hold, !en, $stable(f_ctrl) && $stable(p_ctrl), "stall moved pipeline")
  `RMQ_ASSERT_NEXT(a_setup_adv, en, dv_ctrl[1].valid == $past(p_ctrl.valid), "valid lost in divider")

endmodule
